[rtl/core/four_digit_seven_segment_shifter_top_assert.svh]
// Assertion macros for the seven-segment shifter.
// Used by the top level; depends on nothing else.
`ifndef FOUR_DIGIT_SEVEN_SEGMENT_SHIFTER_TOP_ASSERT_SVH
`define FOUR_DIGIT_SEVEN_SEGMENT_SHIFTER_TOP_ASSERT_SVH

// Same-cycle implication.
`define FDSS_ASSERT_NOW(lbl, ck, rn, a, c) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (a) |-> (c)) \
		else $error("fdss assertion failed");

// Next-cycle implication.
`define FDSS_ASSERT_NEXT(lbl, ck, rn, a, c) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (a) |=> (c)) \
		else $error("fdss assertion failed");

`endif

[rtl/core/fdss_pkg.sv]
// Shared types, constants and microcode for the seven-segment shifter.
// No dependencies; used by fdss_datapath and the top level.
package fdss_pkg;

	localparam int BITS_PER_BYTE = 8;
	localparam int DIGITS        = 4;
	localparam int WORD_W        = 2 * BITS_PER_BYTE;
	localparam int BIT_W         = $clog2(WORD_W);
	localparam int DIGIT_IDX_W   = $clog2(DIGITS);
	localparam int REM_W         = 14;
	localparam logic [15:0] MAX_VALUE = 16'd9999;

	localparam int STEP_W = 3;
	localparam logic [STEP_W-1:0] STEP_WAIT  = 3'd0;
	localparam logic [STEP_W-1:0] STEP_CONV  = 3'd1;
	localparam logic [STEP_W-1:0] STEP_LOW   = 3'd2;
	localparam logic [STEP_W-1:0] STEP_LOADW = 3'd3;
	localparam logic [STEP_W-1:0] STEP_SHIFT = 3'd4;
	localparam logic [STEP_W-1:0] STEP_NEXT  = 3'd5;

	localparam int COND_W = 3;
	localparam logic [COND_W-1:0] COND_ALWAYS     = 3'd0;
	localparam logic [COND_W-1:0] COND_START      = 3'd1;
	localparam logic [COND_W-1:0] COND_CONV_END   = 3'd2;
	localparam logic [COND_W-1:0] COND_BIT_END    = 3'd3;
	localparam logic [COND_W-1:0] COND_LAST_DIGIT = 3'd4;

	typedef struct packed {
		logic load_num;
		logic conv;
		logic store_low;
		logic load_word;
		logic shift;
		logic next_digit;
	} ctl_t;

	typedef struct packed {
		logic in_ok;
		logic conv_end;
		logic bit_end;
		logic last_digit;
	} sts_t;

	typedef struct packed {
		logic              accept;
		logic              emit;
		ctl_t              ctl;
		logic [COND_W-1:0] cond;
		logic [STEP_W-1:0] pc_true;
		logic [STEP_W-1:0] pc_false;
	} ucw_t;

	function automatic ucw_t ucode(input logic [STEP_W-1:0] step);
		ucw_t w;
		w = '0;
		case (step)
			STEP_WAIT: begin
				w.accept = 1'b1; w.ctl.load_num = 1'b1;
				w.cond = COND_START; w.pc_true = STEP_CONV; w.pc_false = STEP_WAIT;
			end
			STEP_CONV: begin
				w.ctl.conv = 1'b1;
				w.cond = COND_CONV_END; w.pc_true = STEP_LOW; w.pc_false = STEP_CONV;
			end
			STEP_LOW: begin
				w.ctl.store_low = 1'b1;
				w.cond = COND_ALWAYS; w.pc_true = STEP_LOADW; w.pc_false = STEP_LOADW;
			end
			STEP_LOADW: begin
				w.ctl.load_word = 1'b1;
				w.cond = COND_ALWAYS; w.pc_true = STEP_SHIFT; w.pc_false = STEP_SHIFT;
			end
			STEP_SHIFT: begin
				w.emit = 1'b1; w.ctl.shift = 1'b1;
				w.cond = COND_BIT_END; w.pc_true = STEP_NEXT; w.pc_false = STEP_SHIFT;
			end
			STEP_NEXT: begin
				w.ctl.next_digit = 1'b1;
				w.cond = COND_LAST_DIGIT; w.pc_true = STEP_WAIT; w.pc_false = STEP_LOADW;
			end
			default: begin
				w.cond = COND_ALWAYS; w.pc_true = STEP_WAIT; w.pc_false = STEP_WAIT;
			end
		endcase
		return w;
	endfunction

	function automatic logic [BITS_PER_BYTE-1:0] seg_pattern(input logic [3:0] dg);
		case (dg)
			4'd0:    return 8'hC0;
			4'd1:    return 8'hF9;
			4'd2:    return 8'hA4;
			4'd3:    return 8'hB0;
			4'd4:    return 8'h99;
			4'd5:    return 8'h92;
			4'd6:    return 8'h82;
			4'd7:    return 8'hF8;
			4'd8:    return 8'h80;
			4'd9:    return 8'h90;
			default: return 8'hC0;
		endcase
	endfunction

	function automatic logic [BITS_PER_BYTE-1:0] sel_pattern(
		input logic [DIGIT_IDX_W-1:0] d);
		case (d)
			2'd0:    return 8'hF1;
			2'd1:    return 8'hF2;
			2'd2:    return 8'hF4;
			default: return 8'hF8;
		endcase
	endfunction

	function automatic logic [REM_W-1:0] weight(input logic [DIGIT_IDX_W-1:0] d);
		case (d)
			2'd0:    return 14'd1000;
			2'd1:    return 14'd100;
			default: return 14'd10;
		endcase
	endfunction

endpackage

[rtl/core/fdss_datapath.sv]
// Datapath of the seven-segment shifter: digit extraction by repeated
// subtraction, digit store, and the 16-bit output shift word. Uses fdss_pkg.
module fdss_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  logic signed [15:0]  number,
	input  fdss_pkg::ctl_t      ctl,
	output fdss_pkg::sts_t      sts,
	output logic                data_bit,
	output logic                latch_after,
	output logic                last
);

	logic [fdss_pkg::REM_W-1:0]        rem_q;
	logic [3:0]                        cnt_q;
	logic [3:0]                        digit_store_q [fdss_pkg::DIGITS];
	logic [fdss_pkg::DIGIT_IDX_W-1:0]  digit_index_q;
	logic [fdss_pkg::BIT_W-1:0]        bit_index_q;
	logic [fdss_pkg::WORD_W-1:0]       shift_word_q;
	logic [fdss_pkg::REM_W-1:0]        w;
	logic                              ge;

	assign w  = fdss_pkg::weight(digit_index_q);
	assign ge = rem_q >= w;

	assign sts.in_ok      = !number[15] && ($unsigned(number) <= fdss_pkg::MAX_VALUE);
	assign sts.conv_end   = !ge && (digit_index_q ==
		fdss_pkg::DIGIT_IDX_W'(fdss_pkg::DIGITS - 2));
	assign sts.bit_end    = bit_index_q == fdss_pkg::BIT_W'(fdss_pkg::WORD_W - 1);
	assign sts.last_digit = digit_index_q == fdss_pkg::DIGIT_IDX_W'(fdss_pkg::DIGITS - 1);

	assign data_bit    = shift_word_q[fdss_pkg::WORD_W-1];
	assign latch_after = sts.bit_end;
	assign last        = sts.bit_end && sts.last_digit;

	always_ff @(posedge clk) begin
		if (ctl.load_num) begin
			rem_q <= number[fdss_pkg::REM_W-1:0];
		end else if (ctl.conv && ge) begin
			rem_q <= rem_q - w;
		end
		if (ctl.conv && !ge) begin
			digit_store_q[digit_index_q] <= cnt_q;
		end
		if (ctl.store_low) begin
			digit_store_q[fdss_pkg::DIGIT_IDX_W'(fdss_pkg::DIGITS - 1)] <= rem_q[3:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q         <= '0;
			digit_index_q <= '0;
			bit_index_q   <= '0;
			shift_word_q  <= '0;
		end else begin
			if (ctl.load_num) begin
				cnt_q         <= '0;
				digit_index_q <= '0;
			end else if (ctl.conv) begin
				if (ge) begin
					cnt_q <= cnt_q + 4'd1;
				end else begin
					cnt_q         <= '0;
					digit_index_q <= digit_index_q + 1'b1;
				end
			end else if (ctl.store_low || ctl.next_digit) begin
				digit_index_q <= ctl.store_low ? '0 : digit_index_q + 1'b1;
			end
			if (ctl.load_word) begin
				shift_word_q <= {fdss_pkg::seg_pattern(digit_store_q[digit_index_q]),
					fdss_pkg::sel_pattern(digit_index_q)};
				bit_index_q  <= '0;
			end else if (ctl.shift) begin
				shift_word_q <= {shift_word_q[fdss_pkg::WORD_W-2:0], 1'b0};
				bit_index_q  <= bit_index_q + 1'b1;
			end
		end
	end

endmodule

[rtl/core/four_digit_seven_segment_shifter_top.sv]
// Channel  Signals                       Request moves
// in       in_valid, in_stall, number    one signed value to display
// out      out_valid, out_stall,         one shift-clock bit with
//          data_bit, latch_after, last   latch and end-of-number flags
//
// A value in 0..9999 is accepted in the wait step. The conversion loop
// subtracts the weight of each leading digit once per unit of that digit
// and moves on when the remainder falls below it, and a separate step
// stores the ones digit. The microcode sequencer then sends each digit as
// a word load, 16 shift bits and a digit advance.
// A value outside 0..9999 is accepted and gives no output.
// Reset is asynchronous, active low; the sequencer returns to its wait step.
// Output stall holds the current bit and the sequencer step.
// Top level: microcode sequencer driving fdss_datapath.
// Depends on fdss_pkg, fdss_datapath and the assertion macro header.
`include "four_digit_seven_segment_shifter_top_assert.svh"

module four_digit_seven_segment_shifter_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [15:0] number,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               data_bit,
	output logic               latch_after,
	output logic               last
);

	logic [fdss_pkg::STEP_W-1:0] pc_q;
	fdss_pkg::ucw_t              ucw;
	fdss_pkg::ctl_t              ctl;
	fdss_pkg::sts_t              sts;
	logic                        cond_hit;

	assign ucw       = fdss_pkg::ucode(pc_q);
	assign in_stall  = !ucw.accept;
	assign out_valid = ucw.emit;

	always_comb begin
		ctl          = ucw.ctl;
		ctl.load_num = ucw.ctl.load_num && in_valid && sts.in_ok;
		ctl.shift    = ucw.ctl.shift && !out_stall;
	end

	always_comb begin
		case (ucw.cond)
			fdss_pkg::COND_ALWAYS:     cond_hit = 1'b1;
			fdss_pkg::COND_START:      cond_hit = in_valid && sts.in_ok;
			fdss_pkg::COND_CONV_END:   cond_hit = sts.conv_end;
			fdss_pkg::COND_BIT_END:    cond_hit = sts.bit_end && !out_stall;
			fdss_pkg::COND_LAST_DIGIT: cond_hit = sts.last_digit;
			default:                   cond_hit = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= fdss_pkg::STEP_WAIT;
		end else begin
			pc_q <= cond_hit ? ucw.pc_true : ucw.pc_false;
		end
	end

	fdss_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.number      (number),
		.ctl         (ctl),
		.sts         (sts),
		.data_bit    (data_bit),
		.latch_after (latch_after),
		.last        (last)
	);

	`FDSS_ASSERT_NOW(a_no_accept_while_emit, clk, arst_n, out_valid, in_stall)
	`FDSS_ASSERT_NEXT(a_no_gap_in_digit, clk, arst_n,
		out_valid && !out_stall && !latch_after, out_valid)
	`FDSS_ASSERT_NEXT(a_start_converts, clk, arst_n,
		in_valid && !in_stall && sts.in_ok, pc_q == fdss_pkg::STEP_CONV)
	`FDSS_ASSERT_NEXT(a_drop_out_of_range, clk, arst_n,
		in_valid && !in_stall && !sts.in_ok, !in_stall)
	`FDSS_ASSERT_NOW(a_first_bit_no_latch, clk, arst_n, $rose(out_valid), !latch_after)

endmodule

[tb/fdss_pulse_checker.sv]
`timescale 1ns / 100ps
// Pulse checker for the four-digit seven-segment shifter: predicts the 64 shift pulses
// of each accepted in-range number and compares every accepted output pulse against them.
// Depends on fdss_pkg for widths and the display range.
module fdss_pulse_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic signed [15:0] number,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic               data_bit,
	input  logic               latch_after,
	input  logic               last,
	output int                 mismatches,
	output int                 pulses_pending
);

	typedef struct packed {
		logic data_bit;
		logic latch_after;
		logic last;
	} shift_pulse_t;

	localparam logic [10*fdss_pkg::BITS_PER_BYTE-1:0] SEG_CODES = {
		8'h90, 8'h80, 8'hF8, 8'h82, 8'h92, 8'h99, 8'hB0, 8'hA4, 8'hF9, 8'hC0};
	localparam logic [fdss_pkg::DIGITS*fdss_pkg::BITS_PER_BYTE-1:0] SEL_CODES = {
		8'hF8, 8'hF4, 8'hF2, 8'hF1};

	shift_pulse_t pulses_due[$];
	int mismatch_total = 0;

	task automatic queue_display_pulses(input logic signed [15:0] value);
		int v;
		int place;
		int dg;
		logic [fdss_pkg::WORD_W-1:0] word;
		shift_pulse_t p;
		v = value;
		if (v >= 0 && v <= int'(fdss_pkg::MAX_VALUE)) begin
			place = 1000;
			for (int d = 0; d < fdss_pkg::DIGITS; d++) begin
				dg = (v / place) % 10;
				place = place / 10;
				word = {SEG_CODES[dg*fdss_pkg::BITS_PER_BYTE +: fdss_pkg::BITS_PER_BYTE],
					SEL_CODES[d*fdss_pkg::BITS_PER_BYTE +: fdss_pkg::BITS_PER_BYTE]};
				for (int b = 0; b < fdss_pkg::WORD_W; b++) begin
					p.data_bit    = word[fdss_pkg::WORD_W-1-b];
					p.latch_after = (b == fdss_pkg::WORD_W - 1);
					p.last        = (d == fdss_pkg::DIGITS - 1) && (b == fdss_pkg::WORD_W - 1);
					pulses_due.push_back(p);
				end
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		shift_pulse_t due;
		if (!arst_n) begin
			pulses_due.delete();
			mismatches <= 0;
			pulses_pending <= 0;
		end else begin
			if (in_valid && !in_stall)
				queue_display_pulses(number);
			if (out_valid && !out_stall) begin
				if (pulses_due.size() == 0) begin
					$error("unexpected pulse: data_bit %0b latch_after %0b last %0b",
						data_bit, latch_after, last);
					mismatch_total++;
				end else begin
					due = pulses_due.pop_front();
					if (data_bit !== due.data_bit) begin
						$error("data_bit: expected %0b, got %0b", due.data_bit, data_bit);
						mismatch_total++;
					end
					if (latch_after !== due.latch_after) begin
						$error("latch_after: expected %0b, got %0b", due.latch_after,
							latch_after);
						mismatch_total++;
					end
					if (last !== due.last) begin
						$error("last: expected %0b, got %0b", due.last, last);
						mismatch_total++;
					end
				end
			end
			mismatches <= mismatch_total;
			pulses_pending <= pulses_due.size();
		end
	end

endmodule

[tb/four_digit_seven_segment_shifter_top_tb.sv]
`timescale 1ns / 100ps
// Top testbench for four_digit_seven_segment_shifter_top: drives numbers and output stall
// across idling phases and gives the verdict. Depends on fdss_pkg and fdss_pulse_checker.
module four_digit_seven_segment_shifter_top_tb;

	localparam int LIMIT_CYCLES  = 400000;
	localparam int HOLD_CYCLES   = 600;
	localparam int DRAIN_CYCLES  = 150;
	localparam int SHOWN_PER_PHASE = 27;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic signed [15:0] number = '0;
	logic               out_stall = 1'b0;
	logic               in_stall;
	logic               out_valid;
	logic               data_bit;
	logic               latch_after;
	logic               last;
	int                 mismatches;
	int                 pulses_pending;

	int   recv_stall_pct = 0;
	int   sender_idle_pct = 0;
	logic long_hold_req = 1'b0;
	int   hold_left = 0;
	int   cycle_count = 0;

	four_digit_seven_segment_shifter_top DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.number      (number),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.data_bit    (data_bit),
		.latch_after (latch_after),
		.last        (last)
	);

	fdss_pulse_checker u_pulse_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.number         (number),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.data_bit       (data_bit),
		.latch_after    (latch_after),
		.last           (last),
		.mismatches     (mismatches),
		.pulses_pending (pulses_pending)
	);

	initial forever #1 clk = ~clk;

	// hold off for a long stretch on request, else stall at random
	always @(posedge clk) begin
		if (long_hold_req) begin
			hold_left <= HOLD_CYCLES - 1;
			out_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	initial begin
		while (cycle_count < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("four_digit_seven_segment_shifter_top regression: fail");
		$finish;
	end

	task automatic offer(input logic signed [15:0] value);
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			number <= 16'($urandom);
			@(posedge clk);
		end
		in_valid <= 1'b1;
		number <= value;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic offer_random(output bit shown);
		if ($urandom_range(99) < 20) begin
			if ($urandom_range(1))
				offer(16'($urandom_range(65535, 32768)));
			else
				offer(16'($urandom_range(32767, 10000)));
			shown = 1'b0;
		end else begin
			offer(16'($urandom_range(9999)));
			shown = 1'b1;
		end
	endtask

	initial begin
		logic signed [15:0] directed_values [20];
		int shown_count;
		bit shown;
		directed_values = '{
			16'sd0, 16'sd9999, 16'sd10000, -16'sd1, -16'sd32768, 16'sd32767,
			16'sd1, 16'sd10, 16'sd100, 16'sd1000, 16'sd1234, 16'sd5678,
			16'sd9012, 16'sd3456, 16'sd7890, 16'sd8888, 16'sd4444, 16'sd0,
			16'sd9998, 16'sd6060};
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_values[i])
			offer(directed_values[i]);

		// fill the block while the receiver holds off
		long_hold_req <= 1'b1;
		@(posedge clk);
		long_hold_req <= 1'b0;
		for (int i = 0; i < 6; i++)
			offer(16'($urandom_range(9999)));

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin sender_idle_pct = 0;  recv_stall_pct <= 0;  end
				1: begin sender_idle_pct = 73; recv_stall_pct <= 0;  end
				2: begin sender_idle_pct = 0;  recv_stall_pct <= 73; end
				default: begin sender_idle_pct = 16; recv_stall_pct <= 16; end
			endcase
			shown_count = 0;
			while (shown_count < SHOWN_PER_PHASE) begin
				offer_random(shown);
				if (shown)
					shown_count++;
			end
		end

		in_valid <= 1'b0;
		@(posedge clk);
		while (pulses_pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("four_digit_seven_segment_shifter_top regression: pass");
		else
			$display("four_digit_seven_segment_shifter_top regression: fail");
		$finish;
	end

endmodule
